@@ rtl/core/ipv4_fragment_reassembly_tracker_assert.svh @@
// assertion macros for the fragment reassembly tracker
// no dependencies; taken in by the files that carry assertions
`ifndef IPV4_FRAGMENT_REASSEMBLY_TRACKER_ASSERT_SVH
`define IPV4_FRAGMENT_REASSEMBLY_TRACKER_ASSERT_SVH

// property checked on every rising edge outside reset
`define IFTR_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("iftr assertion failed");

// expression that must never hold outside reset
`define IFTR_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("iftr forbidden condition");

`endif

@@ rtl/core/iftr_pkg.sv @@
// shared types and constants of the fragment reassembly tracker
// no dependencies
`default_nettype none

package iftr_pkg;

  localparam int unsigned ContextsDef  = 4;
  localparam int unsigned PiecesDef    = 8;
  localparam int unsigned MaxResults   = 32;
  localparam int unsigned ResCntW      = 6;
  localparam logic [15:0] ExpiryReset  = 16'd1000;

  typedef enum logic {
    OP_FRAG  = 1'b0,
    OP_SWEEP = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    KIND_STORED  = 2'd0,
    KIND_DROP    = 2'd1,
    KIND_REASM   = 2'd2,
    KIND_EXPIRED = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    NEXT_FINISH,
    NEXT_DROP,
    NEXT_SWEEP
  } next_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_MATCH,
    ST_OPEN,
    ST_AGE,
    ST_INS_RD,
    ST_INS_EV,
    ST_POST,
    ST_WALK_RD,
    ST_WALK_EV,
    ST_REL_RD,
    ST_REL_EV,
    ST_SWP_CHK,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic        op;
    logic [31:0] now;
    logic [7:0]  protocol;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] ident;
    logic        more_frags;
    logic [12:0] frag_offset;
    logic [3:0]  header_words;
    logic [15:0] total_len;
    logic [7:0]  piece_handle;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  context_slot;
    logic [7:0]  out_handle;
    logic [15:0] piece_offset;
    logic [15:0] piece_len;
    logic [15:0] total_len_out;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [15:0] offset;
    logic [15:0] len;
    logic [7:0]  handle;
  } piece_t;

  // verdict of the shared compare unit for the selected context
  typedef struct packed {
    logic match;
    logic stale;
  } ctx_chk_t;

endpackage

`default_nettype wire

@@ rtl/core/iftr_cmp.sv @@
// shared key compare and age compare unit
// depends on iftr_pkg
`default_nettype none

module iftr_cmp (
  input  wire logic [31:0]        now_i,
  input  wire logic [15:0]        expiry_i,
  input  wire logic [31:0]        last_tick_i,
  input  wire logic [87:0]        ctx_key_i,
  input  wire logic [87:0]        item_key_i,
  output iftr_pkg::ctx_chk_t      chk_o
);

  logic [31:0] age;

  // wrapping age against the expiry threshold
  assign age         = now_i - last_tick_i;
  assign chk_o.stale = (age >= {16'd0, expiry_i});
  assign chk_o.match = (ctx_key_i == item_key_i);

endmodule

`default_nettype wire

@@ rtl/core/iftr_piece_mem.sv @@
// piece store: one write port, one registered read port
// depends on iftr_pkg
`default_nettype none

module iftr_piece_mem #(
  parameter int unsigned Depth = 32,
  parameter int unsigned AddrW = 5
) (
  input  wire logic               clk_i,
  input  wire logic               wr_en_i,
  input  wire logic [AddrW-1:0]   wr_addr_i,
  input  wire iftr_pkg::piece_t   wr_data_i,
  input  wire logic               rd_en_i,
  input  wire logic [AddrW-1:0]   rd_addr_i,
  output iftr_pkg::piece_t        rd_data_o
);

  iftr_pkg::piece_t mem [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/iftr_out_buf.sv @@
// result holding stage and output register; marks the final result
// depends on iftr_pkg and the assertion macro header
`default_nettype none
`include "ipv4_fragment_reassembly_tracker_assert.svh"

module iftr_out_buf (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire iftr_pkg::out_item_t push_data_i,
  output logic                     push_ok_o,
  input  wire logic                flush_i,
  output logic                     flush_ok_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output iftr_pkg::out_item_t      out_data_o
);

  logic                hold_v_q, hold_v_d;
  iftr_pkg::out_item_t hold_q, hold_d;
  logic                out_v_q, out_v_d;
  iftr_pkg::out_item_t out_q, out_d;
  logic                out_free;

  assign out_free   = !out_v_q || out_ready_i;
  assign push_ok_o  = !hold_v_q || out_free;
  assign flush_ok_o = !hold_v_q || out_free;

  // move held result forward on push or flush
  always_comb begin
    hold_v_d = hold_v_q;
    hold_d   = hold_q;
    out_v_d  = out_v_q && !out_ready_i;
    out_d    = out_q;
    if (push_i && push_ok_o) begin
      if (hold_v_q) begin
        out_d      = hold_q;
        out_d.last = 1'b0;
        out_v_d    = 1'b1;
      end
      hold_d   = push_data_i;
      hold_v_d = 1'b1;
    end else if (flush_i && flush_ok_o && hold_v_q) begin
      out_d      = hold_q;
      out_d.last = 1'b1;
      out_v_d    = 1'b1;
      hold_v_d   = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      hold_v_q <= hold_v_d;
      out_v_q  <= out_v_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    hold_q <= hold_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  `IFTR_ASSERT(a_push_holds, clk_i, rst_ni, push_i && push_ok_o |=> hold_v_q)
  `IFTR_ASSERT(a_flush_empties, clk_i, rst_ni, flush_i && flush_ok_o |=> !hold_v_q)
  `IFTR_NEVER(a_no_push_on_flush, clk_i, rst_ni, push_i && flush_i)
  `IFTR_ASSERT(a_flush_shows_last, clk_i, rst_ni,
               flush_i && flush_ok_o && hold_v_q |=> out_valid_o && out_data_o.last)

endmodule

`default_nettype wire

@@ rtl/core/ipv4_fragment_reassembly_tracker.sv @@
// fragment reassembly tracker: a sequencer walks contexts and pieces one step a cycle while
// no result stall holds it, with one shared compare unit and one piece store that has one
// write port and one registered read port. a sweep checks each context in turn and releases
// the pieces of every expired one; a fragment searches the contexts, inserts its piece in
// offset order and walks or releases them. one item at a time; in_ready_o is high only while
// idle. reset clears contexts, sets the expiry threshold to 1000; no store clear.
`default_nettype none

module ipv4_fragment_reassembly_tracker #(
  parameter int unsigned CONTEXTS           = iftr_pkg::ContextsDef,
  parameter int unsigned PIECES_PER_CONTEXT = iftr_pkg::PiecesDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire iftr_pkg::in_item_t  in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output iftr_pkg::out_item_t      out_data_o,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [15:0]         cfg_data_i
);

  localparam int unsigned CXW   = (CONTEXTS > 1) ? $clog2(CONTEXTS) : 1;
  localparam int unsigned PXW   = $clog2(PIECES_PER_CONTEXT);
  localparam int unsigned PCW   = $clog2(PIECES_PER_CONTEXT + 1);
  localparam int unsigned DEPTH = CONTEXTS * PIECES_PER_CONTEXT;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned RW    = 16 + PCW;

  // configuration register
  logic [15:0] expiry_q;
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expiry_q <= iftr_pkg::ExpiryReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      expiry_q <= cfg_data_i;
    end
  end

  // sequencer state
  iftr_pkg::state_e  state_q, state_d;
  iftr_pkg::in_item_t item_q, item_d;
  logic [15:0]       dlen_q, dlen_d;
  logic [CXW:0]      ctx_q, ctx_d;
  logic [PCW-1:0]    pidx_q, pidx_d;
  logic [PXW-1:0]    ins_q, ins_d;
  logic [RW-1:0]     run_q, run_d;
  logic [15:0]       tot_q, tot_d;
  iftr_pkg::kind_e   rkind_q, rkind_d;
  iftr_pkg::next_e   rnext_q, rnext_d;
  logic [iftr_pkg::ResCntW-1:0] rcnt_q, rcnt_d;

  // context table
  logic [CONTEXTS-1:0] vld_q, vld_d;
  logic [CONTEXTS-1:0] end_q, end_d;
  logic [PCW-1:0]      cnt_q  [CONTEXTS];
  logic [PCW-1:0]      cnt_d  [CONTEXTS];
  logic [87:0]         key_q  [CONTEXTS];
  logic [87:0]         key_d  [CONTEXTS];
  logic [3:0]          hw_q   [CONTEXTS];
  logic [3:0]          hw_d   [CONTEXTS];
  logic [31:0]         tick_q [CONTEXTS];
  logic [31:0]         tick_d [CONTEXTS];

  // selected context and shared compare unit
  logic [CXW-1:0]      cx;
  logic [87:0]         item_key;
  iftr_pkg::ctx_chk_t  chk;

  assign cx       = (ctx_q < (CXW+1)'(CONTEXTS)) ? ctx_q[CXW-1:0] : '0;
  assign item_key = {item_q.src_addr, item_q.dst_addr, item_q.protocol, item_q.ident};

  iftr_cmp u_cmp (
    .now_i       (item_q.now),
    .expiry_i    (expiry_q),
    .last_tick_i (tick_q[cx]),
    .ctx_key_i   (key_q[cx]),
    .item_key_i  (item_key),
    .chk_o       (chk)
  );

  // piece store
  logic             mem_we, mem_re;
  logic [AW-1:0]    mem_waddr, mem_raddr;
  iftr_pkg::piece_t mem_wdata, mem_rdata;

  iftr_piece_mem #(
    .Depth (DEPTH),
    .AddrW (AW)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (mem_we),
    .wr_addr_i (mem_waddr),
    .wr_data_i (mem_wdata),
    .rd_en_i   (mem_re),
    .rd_addr_i (mem_raddr),
    .rd_data_o (mem_rdata)
  );

  // result buffer
  logic                gen_req, push, push_ok, flush_req, flush_ok, step_en, cap_hit;
  iftr_pkg::out_item_t gen_res;

  iftr_out_buf u_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (gen_res),
    .push_ok_o   (push_ok),
    .flush_i     (flush_req),
    .flush_ok_o  (flush_ok),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  function automatic logic [AW-1:0] paddr(input logic [CXW-1:0] c, input logic [PXW-1:0] p);
    paddr = AW'(int'(c) * PIECES_PER_CONTEXT + int'(p));
  endfunction

  // item derived values
  logic [15:0]       off16;
  logic [5:0]        hb;
  logic [16:0]       tsum;
  logic              ctx_full;
  logic              have_free;
  logic [CXW-1:0]    free_idx;
  iftr_pkg::piece_t  new_piece;

  assign off16     = {item_q.frag_offset, 3'b000};
  assign hb        = {item_q.header_words, 2'b00};
  assign tsum      = {1'b0, run_q[15:0]} + 17'({hw_q[cx], 2'b00});
  assign ctx_full  = (cnt_q[cx] >= PCW'(PIECES_PER_CONTEXT));
  assign new_piece = '{offset: off16, len: dlen_q, handle: item_q.piece_handle};

  // lowest free context
  always_comb begin
    have_free = 1'b0;
    free_idx  = '0;
    for (int i = CONTEXTS - 1; i >= 0; i--) begin
      if (!vld_q[i]) begin
        have_free = 1'b1;
        free_idx  = CXW'(i);
      end
    end
  end

  assign cap_hit = (rcnt_q == iftr_pkg::ResCntW'(iftr_pkg::MaxResults));
  assign step_en = !((gen_req && !cap_hit && !push_ok) || (flush_req && !flush_ok));
  assign push    = gen_req && !cap_hit && push_ok;

  // next state and datapath control
  always_comb begin
    state_d   = state_q;
    item_d    = item_q;
    dlen_d    = dlen_q;
    ctx_d     = ctx_q;
    pidx_d    = pidx_q;
    ins_d     = ins_q;
    run_d     = run_q;
    tot_d     = tot_q;
    rkind_d   = rkind_q;
    rnext_d   = rnext_q;
    rcnt_d    = rcnt_q;
    vld_d     = vld_q;
    end_d     = end_q;
    cnt_d     = cnt_q;
    key_d     = key_q;
    hw_d      = hw_q;
    tick_d    = tick_q;
    in_ready_o = 1'b0;
    gen_req   = 1'b0;
    gen_res   = '0;
    flush_req = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = new_piece;
    mem_re    = 1'b0;
    mem_raddr = '0;

    unique case (state_q)
      iftr_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          item_d  = in_data_i;
          rcnt_d  = '0;
          ctx_d   = '0;
          state_d = iftr_pkg::ST_START;
        end
      end
      iftr_pkg::ST_START: begin
        if (item_q.op == iftr_pkg::OP_SWEEP) begin
          state_d = iftr_pkg::ST_SWP_CHK;
        end else if (item_q.total_len <= 16'(hb)) begin
          gen_req = 1'b1;
          gen_res = '{kind: iftr_pkg::KIND_DROP, context_slot: 2'd0,
                      out_handle: item_q.piece_handle, piece_offset: off16,
                      piece_len: 16'd0, total_len_out: 16'd0, last: 1'b0};
          state_d = iftr_pkg::ST_FINISH;
        end else begin
          dlen_d  = item_q.total_len - 16'(hb);
          state_d = iftr_pkg::ST_MATCH;
        end
      end
      // one context per cycle through the compare unit
      iftr_pkg::ST_MATCH: begin
        if (ctx_q == (CXW+1)'(CONTEXTS)) begin
          state_d = iftr_pkg::ST_OPEN;
        end else if (vld_q[cx] && chk.match) begin
          state_d = iftr_pkg::ST_AGE;
        end else begin
          ctx_d = ctx_q + 1'b1;
        end
      end
      iftr_pkg::ST_OPEN: begin
        if (!item_q.more_frags || off16 != 16'd0 || !have_free) begin
          gen_req = 1'b1;
          gen_res = '{kind: iftr_pkg::KIND_DROP, context_slot: 2'd0,
                      out_handle: item_q.piece_handle, piece_offset: off16,
                      piece_len: dlen_q, total_len_out: 16'd0, last: 1'b0};
          state_d = iftr_pkg::ST_FINISH;
        end else begin
          vld_d[free_idx]  = 1'b1;
          end_d[free_idx]  = 1'b0;
          cnt_d[free_idx]  = '0;
          key_d[free_idx]  = item_key;
          hw_d[free_idx]   = item_q.header_words;
          tick_d[free_idx] = item_q.now;
          ctx_d            = {1'b0, free_idx};
          state_d          = iftr_pkg::ST_AGE;
        end
      end
      iftr_pkg::ST_AGE: begin
        if (item_q.more_frags && chk.stale) begin
          pidx_d  = '0;
          tot_d   = '0;
          rkind_d = iftr_pkg::KIND_EXPIRED;
          rnext_d = iftr_pkg::NEXT_DROP;
          state_d = iftr_pkg::ST_REL_RD;
        end else if (ctx_full) begin
          gen_req = 1'b1;
          gen_res = '{kind: iftr_pkg::KIND_DROP, context_slot: 2'(cx),
                      out_handle: item_q.piece_handle, piece_offset: off16,
                      piece_len: dlen_q, total_len_out: 16'd0, last: 1'b0};
          state_d = iftr_pkg::ST_FINISH;
        end else begin
          tick_d[cx] = item_q.now;
          ins_d      = PXW'(cnt_q[cx]);
          state_d    = iftr_pkg::ST_INS_RD;
        end
      end
      // sorted insert from the tail, a read state and a write state per shifted piece
      iftr_pkg::ST_INS_RD: begin
        if (ins_q == '0) begin
          mem_we    = 1'b1;
          mem_waddr = paddr(cx, '0);
          state_d   = iftr_pkg::ST_POST;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = paddr(cx, ins_q - 1'b1);
          state_d   = iftr_pkg::ST_INS_EV;
        end
      end
      iftr_pkg::ST_INS_EV: begin
        mem_we    = 1'b1;
        mem_waddr = paddr(cx, ins_q);
        if (mem_rdata.offset > off16) begin
          mem_wdata = mem_rdata;
          ins_d     = ins_q - 1'b1;
          state_d   = iftr_pkg::ST_INS_RD;
        end else begin
          state_d = iftr_pkg::ST_POST;
        end
      end
      iftr_pkg::ST_POST: begin
        cnt_d[cx] = cnt_q[cx] + 1'b1;
        if (!item_q.more_frags) begin
          end_d[cx] = 1'b1;
        end
        if (end_q[cx] || !item_q.more_frags) begin
          pidx_d  = '0;
          run_d   = '0;
          state_d = iftr_pkg::ST_WALK_RD;
        end else begin
          gen_req = 1'b1;
          gen_res = '{kind: iftr_pkg::KIND_STORED, context_slot: 2'(cx),
                      out_handle: item_q.piece_handle, piece_offset: off16,
                      piece_len: dlen_q, total_len_out: 16'd0, last: 1'b0};
          state_d = iftr_pkg::ST_FINISH;
        end
      end
      // contiguity walk from offset zero
      iftr_pkg::ST_WALK_RD: begin
        if (pidx_q == cnt_q[cx]) begin
          if (run_q != '0) begin
            tot_d   = (tsum > 17'h0FFFF || run_q[RW-1:16] != '0) ? 16'hFFFF : tsum[15:0];
            pidx_d  = '0;
            rkind_d = iftr_pkg::KIND_REASM;
            rnext_d = iftr_pkg::NEXT_FINISH;
            state_d = iftr_pkg::ST_REL_RD;
          end else begin
            gen_req = 1'b1;
            gen_res = '{kind: iftr_pkg::KIND_STORED, context_slot: 2'(cx),
                        out_handle: item_q.piece_handle, piece_offset: off16,
                        piece_len: dlen_q, total_len_out: 16'd0, last: 1'b0};
            state_d = iftr_pkg::ST_FINISH;
          end
        end else begin
          mem_re    = 1'b1;
          mem_raddr = paddr(cx, pidx_q[PXW-1:0]);
          state_d   = iftr_pkg::ST_WALK_EV;
        end
      end
      iftr_pkg::ST_WALK_EV: begin
        if (RW'(mem_rdata.offset) != run_q) begin
          gen_req = 1'b1;
          gen_res = '{kind: iftr_pkg::KIND_STORED, context_slot: 2'(cx),
                      out_handle: item_q.piece_handle, piece_offset: off16,
                      piece_len: dlen_q, total_len_out: 16'd0, last: 1'b0};
          state_d = iftr_pkg::ST_FINISH;
        end else begin
          run_d   = run_q + RW'(mem_rdata.len);
          pidx_d  = pidx_q + 1'b1;
          state_d = iftr_pkg::ST_WALK_RD;
        end
      end
      // report every piece of the context, then free it
      iftr_pkg::ST_REL_RD: begin
        if (pidx_q == cnt_q[cx]) begin
          vld_d[cx] = 1'b0;
          end_d[cx] = 1'b0;
          cnt_d[cx] = '0;
          unique case (rnext_q)
            iftr_pkg::NEXT_DROP: begin
              gen_req = 1'b1;
              gen_res = '{kind: iftr_pkg::KIND_DROP, context_slot: 2'(cx),
                          out_handle: item_q.piece_handle, piece_offset: off16,
                          piece_len: dlen_q, total_len_out: 16'd0, last: 1'b0};
              state_d = iftr_pkg::ST_FINISH;
            end
            iftr_pkg::NEXT_SWEEP: begin
              ctx_d   = ctx_q + 1'b1;
              state_d = iftr_pkg::ST_SWP_CHK;
            end
            default: begin
              state_d = iftr_pkg::ST_FINISH;
            end
          endcase
        end else begin
          mem_re    = 1'b1;
          mem_raddr = paddr(cx, pidx_q[PXW-1:0]);
          state_d   = iftr_pkg::ST_REL_EV;
        end
      end
      iftr_pkg::ST_REL_EV: begin
        gen_req = 1'b1;
        gen_res = '{kind: rkind_q, context_slot: 2'(cx), out_handle: mem_rdata.handle,
                    piece_offset: mem_rdata.offset, piece_len: mem_rdata.len,
                    total_len_out: tot_q, last: 1'b0};
        pidx_d  = pidx_q + 1'b1;
        state_d = iftr_pkg::ST_REL_RD;
      end
      // aging sweep, one context per cycle
      iftr_pkg::ST_SWP_CHK: begin
        if (ctx_q == (CXW+1)'(CONTEXTS)) begin
          state_d = iftr_pkg::ST_FINISH;
        end else if (vld_q[cx] && chk.stale) begin
          pidx_d  = '0;
          tot_d   = '0;
          rkind_d = iftr_pkg::KIND_EXPIRED;
          rnext_d = iftr_pkg::NEXT_SWEEP;
          state_d = iftr_pkg::ST_REL_RD;
        end else begin
          ctx_d = ctx_q + 1'b1;
        end
      end
      iftr_pkg::ST_FINISH: begin
        flush_req = 1'b1;
        state_d   = iftr_pkg::ST_IDLE;
      end
      default: begin
        state_d = iftr_pkg::ST_IDLE;
      end
    endcase

    if (push) begin
      rcnt_d = rcnt_q + 1'b1;
    end
    if (!step_en) begin
      mem_we = 1'b0;
      mem_re = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= iftr_pkg::ST_IDLE;
      vld_q   <= '0;
      end_q   <= '0;
      rcnt_q  <= '0;
      for (int i = 0; i < CONTEXTS; i++) begin
        cnt_q[i] <= '0;
      end
    end else if (step_en) begin
      state_q <= state_d;
      vld_q   <= vld_d;
      end_q   <= end_d;
      rcnt_q  <= rcnt_d;
      cnt_q   <= cnt_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (step_en) begin
      item_q  <= item_d;
      dlen_q  <= dlen_d;
      ctx_q   <= ctx_d;
      pidx_q  <= pidx_d;
      ins_q   <= ins_d;
      run_q   <= run_d;
      tot_q   <= tot_d;
      rkind_q <= rkind_d;
      rnext_q <= rnext_d;
      key_q   <= key_d;
      hw_q    <= hw_d;
      tick_q  <= tick_d;
    end
  end

endmodule

`default_nettype wire
